@@ rtl/tipa_pkg.sv @@
// Package for the typed index pool allocator.
// Holds item codes, status codes, controller states and the result item type.
// No dependencies.
package tipa_pkg;

  localparam int unsigned ModeW       = 2;
  localparam int unsigned TypeW       = 3;
  localparam int unsigned SlotW       = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 9;
  localparam int unsigned RecycledW   = 11;
  localparam int unsigned PeakW       = 9;
  localparam int unsigned NumSizeRegs = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_DISCARD = 2'd1,
    MODE_RECYCLE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REC,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [SlotW-1:0]     granted_index;
    logic                 grant_valid;
    status_e              status;
    logic [RecycledW-1:0] recycled_count;
    logic [PeakW-1:0]     peak_in_use;
  } result_t;

endpackage

@@ rtl/tipa_intf.sv @@
// Channel interfaces of the typed index pool allocator: input items,
// result items and size register writes. Depends on tipa_pkg for field widths.
interface tipa_in_if;
  logic                         valid;
  logic                         ready;
  logic [tipa_pkg::ModeW-1:0]   mode;
  logic [tipa_pkg::TypeW-1:0]   pool_type;
  logic [tipa_pkg::SlotW-1:0]   slot_index;

  modport source (output valid, output mode, output pool_type, output slot_index,
                  input ready);
  modport sink   (input valid, input mode, input pool_type, input slot_index,
                  output ready);
endinterface

interface tipa_out_if;
  logic                           valid;
  logic                           ready;
  logic [tipa_pkg::SlotW-1:0]     granted_index;
  logic                           grant_valid;
  logic [1:0]                     status;
  logic [tipa_pkg::RecycledW-1:0] recycled_count;
  logic [tipa_pkg::PeakW-1:0]     peak_in_use;

  modport source (output valid, output granted_index, output grant_valid,
                  output status, output recycled_count, output peak_in_use,
                  input ready);
  modport sink   (input valid, input granted_index, input grant_valid,
                  input status, input recycled_count, input peak_in_use,
                  output ready);
endinterface

interface tipa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tipa_pkg::CfgIdxW-1:0]  index;
  logic [tipa_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tipa_ram.sv @@
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Used for the available rings and the stale lists. No package dependency.
module tipa_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 1280
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DW-1:0]                                wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DW-1:0]                                rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tipa_ctrl.sv @@
// Controller of the typed index pool allocator: per-pool head, count, stale
// count, peak and fill registers, the sequencer and the result register.
// Depends on tipa_pkg and tipa_intf; drives the two tipa_ram instances.
module tipa_ctrl #(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned NUM_POOLS  = 5,
  localparam int unsigned AW = (NUM_POOLS * POOL_DEPTH > 1) ?
                               $clog2(NUM_POOLS * POOL_DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tipa_in_if.sink                  in_i,
  tipa_out_if.source               out_o,
  tipa_cfg_if.sink                 cfg_i,
  // available ring memory
  output logic                     av_we_o,
  output logic [AW-1:0]            av_waddr_o,
  output logic [tipa_pkg::SlotW-1:0] av_wdata_o,
  output logic                     av_re_o,
  output logic [AW-1:0]            av_raddr_o,
  input  logic [tipa_pkg::SlotW-1:0] av_rdata_i,
  // stale list memory
  output logic                     st_we_o,
  output logic [AW-1:0]            st_waddr_o,
  output logic [tipa_pkg::SlotW-1:0] st_wdata_o,
  output logic                     st_re_o,
  output logic [AW-1:0]            st_raddr_o,
  input  logic [tipa_pkg::SlotW-1:0] st_rdata_i
);

  localparam int unsigned PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned NW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned MW = $clog2(NUM_POOLS * POOL_DEPTH + 1);
  localparam logic [CW-1:0] DepthC   = CW'(POOL_DEPTH);
  localparam logic [PW-1:0] LastPosC = PW'(POOL_DEPTH - 1);
  localparam logic [NW-1:0] LastPool = NW'(NUM_POOLS - 1);

  // Per-pool state
  logic [CW-1:0] size_q   [NUM_POOLS];
  logic [PW-1:0] head_q   [NUM_POOLS];
  logic [CW-1:0] count_q  [NUM_POOLS];
  logic [CW-1:0] stale_q  [NUM_POOLS];
  logic [CW-1:0] peak_q   [NUM_POOLS];
  logic [CW-1:0] pushed_q [NUM_POOLS];

  tipa_pkg::fsm_e    state_q, state_d;
  tipa_pkg::result_t res_q, res_d;
  tipa_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              from_mem_q;
  logic [PW-1:0]     pos_q;

  logic [NW-1:0] q_q;
  logic [CW-1:0] k_q;
  logic          rd_v_q;
  logic [MW-1:0] moved_q, moved_d;

  // Item decode
  tipa_pkg::mode_e in_mode;
  logic            in_fire, cfg_fire, cfg_hit, out_free;
  logic            has_pool;
  logic [NW-1:0]   p_in, sel, cfg_p;
  logic [CW-1:0]   sel_size, sel_count, sel_stale, sel_peak, sel_pushed;
  logic [PW-1:0]   sel_head;

  logic [CW:0]     pos_sum, pos_wide;
  logic [PW-1:0]   pos;
  logic            from_mem;
  logic            alloc_ok, disc_range, disc_full, disc_ok;
  logic [CW-1:0]   cnt_dec, in_use, new_peak;
  logic [CW-1:0]   cfg_size;

  logic            issue, pool_done, last_pool;
  logic [PW-1:0]   hd_new;

  assign in_mode  = tipa_pkg::mode_e'(in_i.mode);
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign has_pool = (in_i.pool_type != '0) && (32'(in_i.pool_type) <= NUM_POOLS);
  assign p_in     = has_pool ? NW'(in_i.pool_type - 3'd1) : '0;
  assign sel      = (state_q == tipa_pkg::S_REC) ? q_q : p_in;

  assign sel_size   = size_q[sel];
  assign sel_count  = count_q[sel];
  assign sel_stale  = stale_q[sel];
  assign sel_peak   = peak_q[sel];
  assign sel_pushed = pushed_q[sel];
  assign sel_head   = head_q[sel];

  // Back of the ring: (head + count - 1) mod depth, sum stays below twice the depth
  assign pos_sum  = (CW+1)'(sel_head) + (CW+1)'(sel_count) - (CW+1)'(1);
  assign pos_wide = (pos_sum >= (CW+1)'(POOL_DEPTH)) ? pos_sum - (CW+1)'(POOL_DEPTH)
                                                     : pos_sum;
  assign pos      = PW'(pos_wide);
  // Ring slots at or above depth minus pushes were overwritten; below still identity
  assign from_mem = ((CW+1)'(pos) + (CW+1)'(sel_pushed)) >= (CW+1)'(POOL_DEPTH);

  assign alloc_ok   = has_pool && (sel_count != '0);
  assign cnt_dec    = sel_count - CW'(1);
  assign in_use     = sel_size - cnt_dec;
  assign new_peak   = (in_use > sel_peak) ? in_use : sel_peak;
  assign disc_range = !has_pool || (32'(in_i.slot_index) >= 32'(sel_size));
  assign disc_full  = ((CW+1)'(sel_stale) + (CW+1)'(sel_count)) >= (CW+1)'(sel_size);
  assign disc_ok    = !disc_range && !disc_full;

  // Recycle walk
  assign issue     = k_q < sel_stale;
  assign pool_done = !issue;
  assign last_pool = (q_q == LastPool);
  assign hd_new    = (sel_head == '0) ? LastPosC : sel_head - PW'(1);

  assign cfg_hit  = (32'(cfg_i.index) < tipa_pkg::NumSizeRegs) &&
                    (32'(cfg_i.index) < NUM_POOLS);
  assign cfg_p    = NW'(cfg_i.index);
  assign cfg_size = (32'(cfg_i.data) > POOL_DEPTH) ? DepthC : CW'(cfg_i.data);

  // Memory ports
  assign av_re_o    = in_fire && (in_mode == tipa_pkg::MODE_ALLOC) && alloc_ok;
  assign av_raddr_o = AW'(AW'(sel) * AW'(POOL_DEPTH) + AW'(pos));
  assign av_we_o    = (state_q == tipa_pkg::S_REC) && rd_v_q;
  assign av_waddr_o = AW'(AW'(sel) * AW'(POOL_DEPTH) + AW'(hd_new));
  assign av_wdata_o = st_rdata_i;

  assign st_we_o    = in_fire && (in_mode == tipa_pkg::MODE_DISCARD) && disc_ok;
  assign st_waddr_o = AW'(AW'(sel) * AW'(POOL_DEPTH) + AW'(sel_stale));
  assign st_wdata_o = in_i.slot_index;
  assign st_re_o    = (state_q == tipa_pkg::S_REC) && issue;
  assign st_raddr_o = AW'(AW'(sel) * AW'(POOL_DEPTH) + AW'(k_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tipa_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = (in_mode == tipa_pkg::MODE_RECYCLE) ? tipa_pkg::S_REC
                                                        : tipa_pkg::S_RESP;
        end
      end
      tipa_pkg::S_REC: begin
        if (pool_done && last_pool) begin
          state_d = tipa_pkg::S_RESP;
        end
      end
      tipa_pkg::S_RESP: begin
        if (out_free) begin
          state_d = tipa_pkg::S_IDLE;
        end
      end
      default: state_d = tipa_pkg::S_IDLE;
    endcase
  end

  // Result assembly
  always_comb begin
    res_d       = res_q;
    moved_d     = moved_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      tipa_pkg::S_IDLE: begin
        if (in_fire) begin
          res_d.granted_index  = '0;
          res_d.grant_valid    = 1'b0;
          res_d.status         = tipa_pkg::STAT_OK;
          res_d.recycled_count = '0;
          res_d.peak_in_use    = has_pool ? tipa_pkg::PeakW'(sel_peak) : '0;
          moved_d              = '0;
          case (in_mode)
            tipa_pkg::MODE_ALLOC: begin
              if (alloc_ok) begin
                res_d.grant_valid = 1'b1;
                res_d.peak_in_use = tipa_pkg::PeakW'(new_peak);
              end else begin
                res_d.status = tipa_pkg::STAT_EMPTY;
              end
            end
            tipa_pkg::MODE_DISCARD: begin
              if (disc_range) begin
                res_d.status = tipa_pkg::STAT_RANGE;
              end else if (disc_full) begin
                res_d.status = tipa_pkg::STAT_FULL;
              end
            end
            default: ;
          endcase
        end
      end
      tipa_pkg::S_REC: begin
        if (rd_v_q) begin
          moved_d = moved_q + MW'(1);
        end
        res_d.recycled_count = tipa_pkg::RecycledW'(moved_d);
      end
      tipa_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          if (res_q.grant_valid) begin
            out_d.granted_index = from_mem_q ? av_rdata_i : tipa_pkg::SlotW'(pos_q);
          end
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready  = (state_q == tipa_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.granted_index  = out_q.granted_index;
  assign out_o.grant_valid    = out_q.grant_valid;
  assign out_o.status         = out_q.status;
  assign out_o.recycled_count = out_q.recycled_count;
  assign out_o.peak_in_use    = out_q.peak_in_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tipa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      q_q         <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      moved_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      moved_q     <= moved_d;
      rd_v_q      <= (state_q == tipa_pkg::S_REC) && issue;
      if (in_fire) begin
        q_q <= '0;
        k_q <= '0;
      end else if (state_q == tipa_pkg::S_REC) begin
        if (issue) begin
          k_q <= k_q + CW'(1);
        end else begin
          // advance to the next pool once its stale list is drained
          k_q <= '0;
          if (!last_pool) begin
            q_q <= q_q + NW'(1);
          end
        end
      end
    end
  end

  // Pool registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        size_q[i]   <= '0;
        head_q[i]   <= '0;
        count_q[i]  <= '0;
        stale_q[i]  <= '0;
        peak_q[i]   <= '0;
        pushed_q[i] <= '0;
      end
    end else if (cfg_fire && cfg_hit) begin
      size_q[cfg_p]   <= cfg_size;
      head_q[cfg_p]   <= '0;
      count_q[cfg_p]  <= cfg_size;
      stale_q[cfg_p]  <= '0;
      peak_q[cfg_p]   <= '0;
      pushed_q[cfg_p] <= '0;
    end else if (in_fire) begin
      if ((in_mode == tipa_pkg::MODE_ALLOC) && alloc_ok) begin
        count_q[sel] <= cnt_dec;
        peak_q[sel]  <= new_peak;
      end else if ((in_mode == tipa_pkg::MODE_DISCARD) && disc_ok) begin
        stale_q[sel] <= sel_stale + CW'(1);
      end
    end else if (state_q == tipa_pkg::S_REC) begin
      if (rd_v_q) begin
        head_q[sel]  <= hd_new;
        count_q[sel] <= sel_count + CW'(1);
        if (sel_pushed != DepthC) begin
          pushed_q[sel] <= sel_pushed + CW'(1);
        end
      end
      if (pool_done) begin
        stale_q[sel] <= '0;
      end
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
    if (in_fire) begin
      from_mem_q <= from_mem;
      pos_q      <= pos;
    end
  end

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tipa_pkg::S_IDLE) |->
      (((CW+1)'(sel_count) + (CW+1)'(sel_stale)) <= (CW+1)'(sel_size)))
    else $error("stale plus available entries exceed pool size");

  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (state_q == tipa_pkg::S_REC))
    else $error("stale read returned outside the recycle walk");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tipa_pkg::S_RESP) && !out_free) |=> (state_q == tipa_pkg::S_RESP))
    else $error("result dropped while the output register was full");

  a_walk_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tipa_pkg::S_REC) && pool_done && last_pool) |=> !rd_v_q)
    else $error("stale read still pending after the last pool");

endmodule

@@ rtl/typed_index_pool_allocator_unit.sv @@
// Top level of the typed index pool allocator: controller plus the available
// ring RAM and the stale list RAM. Depends on tipa_pkg, tipa_intf, tipa_ram,
// tipa_ctrl.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    mode, pool_type, slot_index
//   out_o     out  valid/ready    granted_index, grant_valid, status,
//                                 recycled_count, peak_in_use
//   cfg_i     in   valid/ready    index (size register), data
//
// Allocate, discard and the unused mode accept with the ring read, then the
// result is loaded into the output register.
// Recycle walks every pool in turn; within a pool the stale list RAM read
// port moves one entry per cycle into the ring.
// A waiting result holds the controller in its result state; the output
// register lets the next item in as soon as that result is registered.
// Reset leaves the block ready at once: ring slots never written since a pool
// was sized read back as their own position, so there is no clearing pass.
module typed_index_pool_allocator_unit #(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned NUM_POOLS  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tipa_in_if.sink     in_i,
  tipa_out_if.source  out_o,
  tipa_cfg_if.sink    cfg_i
);

  localparam int unsigned MemDepth = NUM_POOLS * POOL_DEPTH;
  localparam int unsigned AW = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic                        av_we, av_re, st_we, st_re;
  logic [AW-1:0]               av_waddr, av_raddr, st_waddr, st_raddr;
  logic [tipa_pkg::SlotW-1:0]  av_wdata, av_rdata, st_wdata, st_rdata;

  tipa_ctrl #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_POOLS  (NUM_POOLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_i      (cfg_i),
    .av_we_o    (av_we),
    .av_waddr_o (av_waddr),
    .av_wdata_o (av_wdata),
    .av_re_o    (av_re),
    .av_raddr_o (av_raddr),
    .av_rdata_i (av_rdata),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .st_re_o    (st_re),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata)
  );

  tipa_ram #(
    .DW    (tipa_pkg::SlotW),
    .DEPTH (MemDepth)
  ) u_avail_ram (
    .clk_i   (clk_i),
    .we_i    (av_we),
    .waddr_i (av_waddr),
    .wdata_i (av_wdata),
    .re_i    (av_re),
    .raddr_i (av_raddr),
    .rdata_o (av_rdata)
  );

  tipa_ram #(
    .DW    (tipa_pkg::SlotW),
    .DEPTH (MemDepth)
  ) u_stale_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

endmodule

@@ bench/tb_typed_index_pool_allocator_unit.sv @@
// Testbench for typed_index_pool_allocator_unit: drives allocate, discard and recycle
// items, predicts every result with a behavioral copy of the pools and checks it.
// Depends on tipa_pkg, the tipa channel interfaces and the RTL of the block.
module tb_typed_index_pool_allocator_unit;

  localparam int PoolDepth  = 256;
  localparam int NumPools   = 5;
  localparam int CycleLimit = 1_000_000;

  logic clk;
  logic rst_n;

  tipa_in_if  in_if ();
  tipa_out_if out_if ();
  tipa_cfg_if cfg_if ();

  typed_index_pool_allocator_unit #(
    .POOL_DEPTH(PoolDepth),
    .NUM_POOLS (NumPools)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Pool model
  logic [8:0] size_r    [NumPools];
  logic [7:0] ring      [NumPools][PoolDepth];
  logic [7:0] ring_head [NumPools];
  logic [8:0] avail_n   [NumPools];
  logic [7:0] stale     [NumPools][PoolDepth];
  logic [8:0] stale_n   [NumPools];
  logic [8:0] peak      [NumPools];

  // Indices currently handed out, used to build well-formed discards
  logic [7:0] held_idx  [NumPools][PoolDepth];
  int         held_n    [NumPools];

  tipa_pkg::result_t pool_replies_q[$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  function automatic void init_pool_model(input int p);
    for (int i = 0; i < PoolDepth; i++) begin
      ring[p][i] = 8'(i);
    end
    ring_head[p] = '0;
    avail_n[p]   = size_r[p];
    stale_n[p]   = '0;
    peak[p]      = '0;
    held_n[p]    = 0;
  endfunction

  function automatic void apply_pool_size(input logic [tipa_pkg::CfgIdxW-1:0] idx,
                                          input logic [tipa_pkg::CfgDataW-1:0] value);
    int p;
    p = int'(idx);
    if (p >= tipa_pkg::NumSizeRegs || p >= NumPools) return;
    size_r[p] = (value > 9'(PoolDepth)) ? 9'(PoolDepth) : value;
    init_pool_model(p);
  endfunction

  function automatic tipa_pkg::result_t predict_pool_step(
      input tipa_pkg::mode_e mode,
      input logic [tipa_pkg::TypeW-1:0] ptype,
      input logic [tipa_pkg::SlotW-1:0] slot);
    tipa_pkg::result_t r;
    logic    has_pool;
    int      p;
    logic [7:0]  pos;
    logic [8:0]  in_use;
    logic [10:0] moved;
    r        = '0;
    moved    = '0;
    has_pool = (ptype >= 3'd1) && (int'(ptype) <= NumPools);
    p        = has_pool ? int'(ptype) - 1 : 0;
    case (mode)
      tipa_pkg::MODE_ALLOC: begin
        if (!has_pool || avail_n[p] == 9'd0) begin
          r.status = tipa_pkg::STAT_EMPTY;
        end else begin
          // pop the back of the deque
          pos = ring_head[p] + avail_n[p][7:0] - 8'd1;
          r.granted_index = ring[p][pos];
          r.grant_valid   = 1'b1;
          avail_n[p]      = avail_n[p] - 9'd1;
          in_use          = size_r[p] - avail_n[p];
          if (in_use > peak[p]) peak[p] = in_use;
          held_idx[p][held_n[p]] = r.granted_index;
          held_n[p]++;
        end
      end
      tipa_pkg::MODE_DISCARD: begin
        if (!has_pool || {1'b0, slot} >= size_r[p]) begin
          r.status = tipa_pkg::STAT_RANGE;
        end else if ({1'b0, stale_n[p]} + {1'b0, avail_n[p]} >= {1'b0, size_r[p]}) begin
          r.status = tipa_pkg::STAT_FULL;
        end else begin
          stale[p][stale_n[p][7:0]] = slot;
          stale_n[p] = stale_n[p] + 9'd1;
        end
      end
      tipa_pkg::MODE_RECYCLE: begin
        // push stale entries, in list order, onto the front of each pool
        for (int q = 0; q < NumPools; q++) begin
          for (int k = 0; k < int'(stale_n[q]) && k < PoolDepth; k++) begin
            if (avail_n[q] >= 9'(PoolDepth)) break;
            ring_head[q] = ring_head[q] - 8'd1;
            ring[q][ring_head[q]] = stale[q][k];
            avail_n[q] = avail_n[q] + 9'd1;
            moved = moved + 11'd1;
          end
          stale_n[q] = '0;
        end
      end
      default: ;
    endcase
    r.recycled_count = moved;
    r.peak_in_use    = has_pool ? peak[p] : '0;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    tipa_pkg::result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pool_replies_q.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pool_replies_q.pop_front();
        if (out_if.granted_index !== want.granted_index)
          report_mismatch("granted_index", int'(out_if.granted_index),
                          int'(want.granted_index));
        if (out_if.grant_valid !== want.grant_valid)
          report_mismatch("grant_valid", int'(out_if.grant_valid), int'(want.grant_valid));
        if (out_if.status !== want.status)
          report_mismatch("status", int'(out_if.status), int'(want.status));
        if (out_if.recycled_count !== want.recycled_count)
          report_mismatch("recycled_count", int'(out_if.recycled_count),
                          int'(want.recycled_count));
        if (out_if.peak_in_use !== want.peak_in_use)
          report_mismatch("peak_in_use", int'(out_if.peak_in_use), int'(want.peak_in_use));
      end
    end
  end

  // Result receiver: random stalls, or a counted hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input tipa_pkg::mode_e mode,
                           input logic [tipa_pkg::TypeW-1:0] ptype,
                           input logic [tipa_pkg::SlotW-1:0] slot);
    tipa_pkg::result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.mode       = mode;
    in_if.pool_type  = ptype;
    in_if.slot_index = slot;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    predicted = predict_pool_step(mode, ptype, slot);
    pool_replies_q.insert(pool_replies_q.size(), predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pool_replies_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_size(input logic [tipa_pkg::CfgIdxW-1:0] idx,
                            input logic [tipa_pkg::CfgDataW-1:0] value);
    wait_drained();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    apply_pool_size(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Pop a random held index of pool p and discard it
  task automatic discard_held(input int p);
    int k;
    logic [7:0] slot;
    k    = $urandom_range(held_n[p] - 1);
    slot = held_idx[p][k];
    held_idx[p][k] = held_idx[p][held_n[p] - 1];
    held_n[p]--;
    send_item(tipa_pkg::MODE_DISCARD, tipa_pkg::TypeW'(p + 1), slot);
  endtask

  function automatic logic [tipa_pkg::CfgDataW-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 75) return tipa_pkg::CfgDataW'($urandom_range(12));
    if (r < 85) return tipa_pkg::CfgDataW'(PoolDepth);
    if (r < 92) return tipa_pkg::CfgDataW'($urandom_range(511, 257));
    return tipa_pkg::CfgDataW'($urandom_range(255, 13));
  endfunction

  task automatic test_directed_cases();
    send_item(tipa_pkg::MODE_ALLOC, 3'd1, 8'd0);        // pool of size zero
    write_size(3'd0, 9'd1);
    write_size(3'd1, 9'd3);
    write_size(3'd2, 9'd0);
    write_size(3'd3, 9'd511);                           // saturates to full depth
    write_size(3'd4, 9'd2);
    write_size(3'd5, 9'd300);                           // no such register
    write_size(3'd7, 9'd511);
    send_item(tipa_pkg::MODE_ALLOC, 3'd1, 8'd0);
    send_item(tipa_pkg::MODE_ALLOC, 3'd1, 8'd255);      // now empty
    send_item(tipa_pkg::MODE_DISCARD, 3'd1, 8'd0);
    send_item(tipa_pkg::MODE_DISCARD, 3'd1, 8'd0);      // stale list full
    send_item(tipa_pkg::MODE_DISCARD, 3'd1, 8'd1);      // out of range
    send_item(tipa_pkg::MODE_ALLOC, 3'd0, 8'd0);        // no pool
    send_item(tipa_pkg::MODE_ALLOC, 3'd6, 8'd0);
    send_item(tipa_pkg::MODE_ALLOC, 3'd7, 8'd0);
    send_item(tipa_pkg::MODE_DISCARD, 3'd0, 8'd0);
    send_item(tipa_pkg::MODE_DISCARD, 3'd7, 8'd255);
    send_item(tipa_pkg::MODE_NONE, 3'd2, 8'd170);
    send_item(tipa_pkg::MODE_ALLOC, 3'd4, 8'd85);
    send_item(tipa_pkg::MODE_DISCARD, 3'd4, 8'd255);
    send_item(tipa_pkg::MODE_DISCARD, 3'd4, 8'd0);      // stale plus available at size
    send_item(tipa_pkg::MODE_DISCARD, 3'd3, 8'd0);      // pool sized zero
    send_item(tipa_pkg::MODE_RECYCLE, 3'd7, 8'd255);
    send_item(tipa_pkg::MODE_ALLOC, 3'd4, 8'd0);
    send_item(tipa_pkg::MODE_ALLOC, 3'd1, 8'd0);
    send_item(tipa_pkg::MODE_RECYCLE, 3'd0, 8'd0);      // nothing stale
    send_item(tipa_pkg::MODE_NONE, 3'd5, 8'd0);
  endtask

  task automatic test_backpressure();
    int saved;
    write_size(3'd1, 9'd40);
    saved         = send_idle_pct;
    send_idle_pct = 0;
    hold_cycles   = 300;
    for (int i = 0; i < 30; i++) begin
      send_item((i % 4 == 3) ? tipa_pkg::MODE_DISCARD : tipa_pkg::MODE_ALLOC, 3'd2,
                8'($urandom_range(45)));
    end
    // pause until every result is back
    wait_drained();
    send_idle_pct = saved;
  endtask

  task automatic test_full_pool();
    write_size(3'd4, 9'd256);
    for (int i = 0; i <= PoolDepth; i++) begin
      send_item(tipa_pkg::MODE_ALLOC, 3'd5, 8'($urandom));
    end
    while (held_n[4] > 0) discard_held(4);
    send_item(tipa_pkg::MODE_DISCARD, 3'd5, 8'($urandom));
    send_item(tipa_pkg::MODE_RECYCLE, 3'($urandom), 8'($urandom));
    send_item(tipa_pkg::MODE_ALLOC, 3'd5, 8'd0);
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    int pick;
    int p;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 90 == 0) begin
        repeat ($urandom_range(1, 3)) write_size(3'($urandom_range(4)), pick_size());
        if ($urandom_range(3) == 0) write_size(3'($urandom_range(7, 5)), 9'($urandom));
      end
      pick = $urandom_range(99);
      p    = $urandom_range(NumPools - 1);
      if (pick < 42) begin
        send_item(tipa_pkg::MODE_ALLOC, 3'(p + 1), 8'($urandom));
      end else if (pick < 72 && held_n[p] > 0) begin
        discard_held(p);
      end else if (pick < 80) begin
        send_item(tipa_pkg::MODE_RECYCLE, 3'($urandom), 8'($urandom));
      end else begin
        send_item(tipa_pkg::mode_e'($urandom_range(3)), 3'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.mode       = tipa_pkg::MODE_ALLOC;
    in_if.pool_type  = '0;
    in_if.slot_index = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    rst_n            = 1'b0;
    for (int p = 0; p < NumPools; p++) begin
      size_r[p] = '0;
      init_pool_model(p);
    end
    send_idle_pct = 30;
    recv_idle_pct = 58;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_backpressure();
    test_full_pool();
    test_random_traffic(270, 30, 58);
    test_random_traffic(270, 58, 30);
    test_random_traffic(270, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (pool_replies_q.size() != 0) report_mismatch("results never returned",
                                                    0, pool_replies_q.size());
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ typed_index_pool_allocator_unit.f @@
rtl/tipa_pkg.sv
rtl/tipa_intf.sv
rtl/tipa_ram.sv
rtl/tipa_ctrl.sv
rtl/typed_index_pool_allocator_unit.sv
bench/tb_typed_index_pool_allocator_unit.sv
